@@ rtl/mlcr_pkg.sv @@
// ----------------------------------------------------------------------------
// mlcr_pkg
// Shared types, constants and width helpers for the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlcr_pkg;

  localparam int COLOR_BITS = 8;
  // one quotient bit per divider iteration
  localparam int DIV_STEPS  = COLOR_BITS;
  localparam int LANES      = 3;

  typedef logic [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
  } rgb_t;

  // slope class of an x-ordered line
  typedef enum logic [1:0] {
    OCT_SHALLOW_UP = 2'd0,   // 0 <= dy <= dx
    OCT_STEEP_UP   = 2'd1,   // dy > dx
    OCT_SHALLOW_DN = 2'd2,   // -dx <= dy < 0
    OCT_STEEP_DN   = 2'd3    // dy < -dx
  } octant_t;

  // width of one classified line command in the front-to-back queue
  function automatic int cmd_bits(input int coord_bits);
    return 6 * coord_bits + 11 + 6 * COLOR_BITS;
  endfunction

  // width of one pixel beat in the result queue
  function automatic int pix_bits(input int coord_bits);
    return 2 * coord_bits + LANES * COLOR_BITS + 1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mlcr_fifo.sv @@
// ----------------------------------------------------------------------------
// mlcr_fifo
// Small show-ahead queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mlcr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CNTW-1:0]  count_r;
  logic             wr_en;
  logic             rd_en;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign wr_en   = push && !full;
  assign rd_en   = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/mlcr_front.sv @@
// ----------------------------------------------------------------------------
// mlcr_front
// Orders endpoints by x, classifies slope octant, sets up decision terms.
// ----------------------------------------------------------------------------
`default_nettype none

module mlcr_front #(
  parameter int COORD_BITS = 6
) (
  input  logic                                        in_push,
  output logic                                        in_full,
  input  logic signed [COORD_BITS-1:0]                in_start_x,
  input  logic signed [COORD_BITS-1:0]                in_start_y,
  input  logic signed [COORD_BITS-1:0]                in_end_x,
  input  logic signed [COORD_BITS-1:0]                in_end_y,
  input  mlcr_pkg::color_t                            in_start_red,
  input  mlcr_pkg::color_t                            in_start_green,
  input  mlcr_pkg::color_t                            in_start_blue,
  input  mlcr_pkg::color_t                            in_end_red,
  input  mlcr_pkg::color_t                            in_end_green,
  input  mlcr_pkg::color_t                            in_end_blue,
  input  logic                                        q_full,
  output logic                                        q_push,
  output logic [mlcr_pkg::cmd_bits(COORD_BITS)-1:0]   q_data
);

  import mlcr_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 3;

  typedef struct packed {
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic [CW-1:0]        len;
    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] inc_a;    // axis-only step
    logic signed [DW-1:0] inc_b;    // diagonal step
    octant_t              oct;
    rgb_t                 c0;
    rgb_t                 c1;
  } cmd_t;

  logic                 swap;
  logic signed [CW-1:0] x0, y0, x1, y1;
  rgb_t                 ca, cb;
  logic signed [DW-1:0] dx, dy, ady, dx2, dy2, len_w;
  logic                 degenerate;
  cmd_t                 cmd;

  assign swap = (in_start_x > in_end_x);
  assign x0   = swap ? in_end_x   : in_start_x;
  assign y0   = swap ? in_end_y   : in_start_y;
  assign x1   = swap ? in_start_x : in_end_x;
  assign y1   = swap ? in_start_y : in_end_y;

  assign ca = swap ? rgb_t'{red: in_end_red, green: in_end_green, blue: in_end_blue}
                   : rgb_t'{red: in_start_red, green: in_start_green, blue: in_start_blue};
  assign cb = swap ? rgb_t'{red: in_start_red, green: in_start_green, blue: in_start_blue}
                   : rgb_t'{red: in_end_red, green: in_end_green, blue: in_end_blue};

  assign dx  = DW'(x1) - DW'(x0);
  assign dy  = DW'(y1) - DW'(y0);
  assign ady = dy[DW-1] ? -dy : dy;
  assign dx2 = dx + dx;
  assign dy2 = dy + dy;

  assign degenerate = (dx == '0) && (dy == '0);

  always_comb begin
    cmd    = '0;
    cmd.x0 = x0;
    cmd.y0 = y0;
    cmd.c0 = ca;
    cmd.c1 = cb;
    if (!dy[DW-1]) begin
      cmd.oct = (dy <= dx) ? OCT_SHALLOW_UP : OCT_STEEP_UP;
    end else begin
      cmd.oct = (ady <= dx) ? OCT_SHALLOW_DN : OCT_STEEP_DN;
    end
    unique case (cmd.oct)
      OCT_SHALLOW_UP: begin
        cmd.d0    = dy2 - dx;
        cmd.inc_a = dy2;
        cmd.inc_b = dy2 - dx2;
        len_w     = dx;
      end
      OCT_STEEP_UP: begin
        cmd.d0    = dx2 - dy;
        cmd.inc_a = dx2;
        cmd.inc_b = dx2 - dy2;
        len_w     = ady;
      end
      OCT_SHALLOW_DN: begin
        cmd.d0    = dy2 + dx;
        cmd.inc_a = dy2;
        cmd.inc_b = dy2 + dx2;
        len_w     = dx;
      end
      OCT_STEEP_DN: begin
        cmd.d0    = dx2 + dy;
        cmd.inc_a = dx2;
        cmd.inc_b = dx2 + dy2;
        len_w     = ady;
      end
    endcase
    cmd.len = len_w[CW-1:0];
  end

  // a zero-length line is taken and dropped here
  assign in_full = q_full;
  assign q_push  = in_push && !q_full && !degenerate;
  assign q_data  = cmd;

endmodule

`default_nettype wire

@@ rtl/mlcr_back.sv @@
// ----------------------------------------------------------------------------
// mlcr_back
// Color step divider and midpoint walker, one pixel per cycle while walking and the pixel queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module mlcr_back #(
  parameter int COORD_BITS = 6
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        q_empty,
  input  logic [mlcr_pkg::cmd_bits(COORD_BITS)-1:0]   q_data,
  output logic                                        q_pop,
  input  logic                                        pix_full,
  output logic                                        pix_push,
  output logic signed [COORD_BITS-1:0]                pix_x,
  output logic signed [COORD_BITS-1:0]                pix_y,
  output mlcr_pkg::color_t                            pix_red,
  output mlcr_pkg::color_t                            pix_green,
  output mlcr_pkg::color_t                            pix_blue,
  output logic                                        pix_last
);

  import mlcr_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int DW  = COORD_BITS + 3;
  localparam int DCW = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic [CW-1:0]        len;
    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] inc_a;
    logic signed [DW-1:0] inc_b;
    octant_t              oct;
    rgb_t                 c0;
    rgb_t                 c1;
  } cmd_t;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIX, S_WALK} state_t;

  state_t               state_r;
  cmd_t                 cmd_r;
  cmd_t                 q_cmd;
  logic [DCW-1:0]       div_cnt_r;

  // per channel: divider, step (qd, rd), running quotient and remainder
  logic [CW-1:0]        div_rem_r [LANES];
  color_t               div_quo_r [LANES];
  logic                 neg_r     [LANES];
  color_t               qd_r      [LANES];
  logic [CW-1:0]        rd_r      [LANES];
  color_t               q_r       [LANES];
  logic [CW-1:0]        r_r       [LANES];

  logic signed [CW-1:0] x_r, y_r;
  logic signed [DW-1:0] d_r;
  logic [CW-1:0]        k_r;

  color_t               in_c0     [LANES];
  color_t               in_c1     [LANES];
  color_t               mag       [LANES];
  logic                 neg       [LANES];
  logic [CW-1:0]        div_rem_nxt [LANES];
  color_t               div_quo_nxt [LANES];
  color_t               qd_fix    [LANES];
  logic [CW-1:0]        rd_fix    [LANES];
  color_t               q_nxt     [LANES];
  logic [CW-1:0]        r_nxt     [LANES];

  logic signed [CW-1:0] x_nxt, y_nxt;
  logic signed [DW-1:0] d_nxt;
  logic                 diag;
  logic                 walk_go;
  logic                 last;

  assign q_cmd = q_data;

  always_comb begin
    logic [COLOR_BITS:0] delta;
    logic [CW:0]         shifted;
    logic [CW:0]         rsum;
    logic                wrap;
    in_c0[0] = q_cmd.c0.red;
    in_c0[1] = q_cmd.c0.green;
    in_c0[2] = q_cmd.c0.blue;
    in_c1[0] = q_cmd.c1.red;
    in_c1[1] = q_cmd.c1.green;
    in_c1[2] = q_cmd.c1.blue;
    for (int i = 0; i < LANES; i++) begin
      // delta = c1 - c0 split into sign and magnitude for the divider
      delta  = {1'b0, in_c1[i]} - {1'b0, in_c0[i]};
      neg[i] = delta[COLOR_BITS];
      mag[i] = neg[i] ? COLOR_BITS'(-delta) : delta[COLOR_BITS-1:0];

      // restoring divide step, |delta| / len
      shifted = {div_rem_r[i], div_quo_r[i][COLOR_BITS-1]};
      if (shifted >= {1'b0, cmd_r.len}) begin
        div_rem_nxt[i] = CW'(shifted - {1'b0, cmd_r.len});
        div_quo_nxt[i] = {div_quo_r[i][COLOR_BITS-2:0], 1'b1};
      end else begin
        div_rem_nxt[i] = shifted[CW-1:0];
        div_quo_nxt[i] = {div_quo_r[i][COLOR_BITS-2:0], 1'b0};
      end

      // floor division for a negative delta; quotient kept mod 2^8
      if (neg_r[i] && (div_rem_r[i] != '0)) begin
        qd_fix[i] = ~div_quo_r[i];
        rd_fix[i] = cmd_r.len - div_rem_r[i];
      end else begin
        qd_fix[i] = neg_r[i] ? -div_quo_r[i] : div_quo_r[i];
        rd_fix[i] = div_rem_r[i];
      end

      // color advance by one major-axis step
      rsum = {1'b0, r_r[i]} + {1'b0, rd_r[i]};
      wrap = (rsum >= {1'b0, cmd_r.len});
      r_nxt[i] = wrap ? CW'(rsum - {1'b0, cmd_r.len}) : rsum[CW-1:0];
      q_nxt[i] = q_r[i] + qd_r[i] + COLOR_BITS'(wrap);
    end
  end

  // midpoint step
  always_comb begin
    if (cmd_r.oct == OCT_SHALLOW_DN) begin
      diag = d_r[DW-1] || (d_r == '0);
    end else begin
      diag = !d_r[DW-1] && (d_r != '0);
    end
    d_nxt = d_r + (diag ? cmd_r.inc_b : cmd_r.inc_a);
    unique case (cmd_r.oct)
      OCT_SHALLOW_UP: begin
        x_nxt = x_r + 1'b1;
        y_nxt = y_r + CW'(diag);
      end
      OCT_STEEP_UP: begin
        x_nxt = x_r + CW'(diag);
        y_nxt = y_r + 1'b1;
      end
      OCT_SHALLOW_DN: begin
        x_nxt = x_r + 1'b1;
        y_nxt = y_r - CW'(diag);
      end
      OCT_STEEP_DN: begin
        x_nxt = x_r + CW'(diag);
        y_nxt = y_r - 1'b1;
      end
    endcase
  end

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign walk_go  = (state_r == S_WALK) && !pix_full;
  assign last     = (k_r == cmd_r.len);

  assign pix_push  = walk_go;
  assign pix_x     = x_nxt;
  assign pix_y     = y_nxt;
  assign pix_red   = q_nxt[0];
  assign pix_green = q_nxt[1];
  assign pix_blue  = q_nxt[2];
  assign pix_last  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cmd_r     <= q_cmd;
            div_cnt_r <= '0;
            for (int i = 0; i < LANES; i++) begin
              div_rem_r[i] <= '0;
              div_quo_r[i] <= mag[i];
              neg_r[i]     <= neg[i];
            end
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          for (int i = 0; i < LANES; i++) begin
            div_rem_r[i] <= div_rem_nxt[i];
            div_quo_r[i] <= div_quo_nxt[i];
          end
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DCW'(DIV_STEPS - 1)) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          for (int i = 0; i < LANES; i++) begin
            qd_r[i] <= qd_fix[i];
            rd_r[i] <= rd_fix[i];
            r_r[i]  <= cmd_r.len >> 1;
          end
          q_r[0]  <= cmd_r.c0.red;
          q_r[1]  <= cmd_r.c0.green;
          q_r[2]  <= cmd_r.c0.blue;
          x_r     <= cmd_r.x0;
          y_r     <= cmd_r.y0;
          d_r     <= cmd_r.d0;
          k_r     <= CW'(1);
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (walk_go) begin
            for (int i = 0; i < LANES; i++) begin
              q_r[i] <= q_nxt[i];
              r_r[i] <= r_nxt[i];
            end
            x_r <= x_nxt;
            y_r <= y_nxt;
            d_r <= d_nxt;
            k_r <= k_r + 1'b1;
            if (last) begin
              state_r <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/midpoint_line_color_raster.sv @@
// ----------------------------------------------------------------------------
// midpoint_line_color_raster
// Midpoint line rasterizer with linear RGB interpolation along the line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one line command per beat (two signed endpoints and an RGB
//   color at each end), pushed with in_push while in_full is low.
//   Result channel: one pixel per beat, read with out_pop while out_empty is
//   low; out_last_pixel marks the final pixel of a line. The start cell is
//   never emitted; a line with equal endpoints emits nothing.
//   The front classifies a command in the cycle it is pushed and parks it in
//   a two-entry command queue, so a second command can be taken while the
//   back is still drawing.
//   Back sequence per line of major length L: a load step, the three-channel
//   color step divider (one per channel, stepped together), a setup step,
//   then L pixels at one per cycle while the pixel queue has room. The back
//   takes the next line from the command queue only after the last pixel
//   of the current one.
//   When the receiver stops popping, the two-entry pixel queue fills and the
//   walker holds its position; nothing is lost.
//   Reset (rst_n low, synchronous) empties both queues and idles the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_line_color_raster #(
  parameter int COORD_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  mlcr_pkg::color_t             in_start_red,
  input  mlcr_pkg::color_t             in_start_green,
  input  mlcr_pkg::color_t             in_start_blue,
  input  mlcr_pkg::color_t             in_end_red,
  input  mlcr_pkg::color_t             in_end_green,
  input  mlcr_pkg::color_t             in_end_blue,
  // pixel channel
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output mlcr_pkg::color_t             out_pixel_red,
  output mlcr_pkg::color_t             out_pixel_green,
  output mlcr_pkg::color_t             out_pixel_blue,
  output logic                         out_last_pixel
);

  import mlcr_pkg::*;

  localparam int CMDW  = cmd_bits(COORD_BITS);
  localparam int PIXW  = pix_bits(COORD_BITS);
  localparam int QDEPTH = 2;

  // front -> command queue
  logic                  cq_push;
  logic                  cq_full;
  logic [CMDW-1:0]       cq_wdata;
  // command queue -> back
  logic                  cq_pop;
  logic                  cq_empty;
  logic [CMDW-1:0]       cq_rdata;
  // back -> pixel queue
  logic                  pq_push;
  logic                  pq_full;
  logic signed [COORD_BITS-1:0] px_x, px_y;
  color_t                px_red, px_green, px_blue;
  logic                  px_last;
  logic [PIXW-1:0]       pq_rdata;

  mlcr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_push        (in_push),
    .in_full        (in_full),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_start_red   (in_start_red),
    .in_start_green (in_start_green),
    .in_start_blue  (in_start_blue),
    .in_end_red     (in_end_red),
    .in_end_green   (in_end_green),
    .in_end_blue    (in_end_blue),
    .q_full         (cq_full),
    .q_push         (cq_push),
    .q_data         (cq_wdata)
  );

  mlcr_fifo #(.WIDTH(CMDW), .DEPTH(QDEPTH)) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cq_push),
    .wr_data (cq_wdata),
    .full    (cq_full),
    .pop     (cq_pop),
    .rd_data (cq_rdata),
    .empty   (cq_empty)
  );

  mlcr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (cq_empty),
    .q_data    (cq_rdata),
    .q_pop     (cq_pop),
    .pix_full  (pq_full),
    .pix_push  (pq_push),
    .pix_x     (px_x),
    .pix_y     (px_y),
    .pix_red   (px_red),
    .pix_green (px_green),
    .pix_blue  (px_blue),
    .pix_last  (px_last)
  );

  mlcr_fifo #(.WIDTH(PIXW), .DEPTH(QDEPTH)) u_pix_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (pq_push),
    .wr_data ({px_x, px_y, px_red, px_green, px_blue, px_last}),
    .full    (pq_full),
    .pop     (out_pop),
    .rd_data (pq_rdata),
    .empty   (out_empty)
  );

  assign {out_pixel_x, out_pixel_y, out_pixel_red, out_pixel_green,
          out_pixel_blue, out_last_pixel} = pq_rdata;

endmodule

`default_nettype wire

@@ rtl/mlcr_checker.sv @@
// ----------------------------------------------------------------------------
// mlcr_checker
// Port-level assertions for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlcr_checker #(
  parameter int COORD_BITS = 6
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_full,
  input logic                         out_empty,
  input logic                         out_pop,
  input logic signed [COORD_BITS-1:0] out_pixel_x,
  input logic signed [COORD_BITS-1:0] out_pixel_y,
  input mlcr_pkg::color_t             out_pixel_red,
  input mlcr_pkg::color_t             out_pixel_green,
  input mlcr_pkg::color_t             out_pixel_blue,
  input logic                         out_last_pixel
);

  logic [COORD_BITS-1:0] px_prev_r;
  logic [COORD_BITS-1:0] py_prev_r;
  logic [COORD_BITS-1:0] x_diff;
  logic [COORD_BITS-1:0] y_diff;
  logic                  mid_line_pop;

  always_ff @(posedge clk) begin
    px_prev_r <= out_pixel_x;
    py_prev_r <= out_pixel_y;
  end

  assign x_diff       = out_pixel_x - px_prev_r;
  assign y_diff       = out_pixel_y - py_prev_r;
  assign mid_line_pop = out_pop && !out_empty && !out_last_pixel;

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a waiting pixel beat holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_pixel_x) &&
      $stable(out_pixel_y) && $stable(out_pixel_red) &&
      $stable(out_pixel_green) && $stable(out_pixel_blue) &&
      $stable(out_last_pixel))
    else $error("pixel beat changed while stalled");

  // within a line, x never falls and y moves by at most one cell
  a_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    mid_line_pop ##1 !out_empty |->
      (x_diff == '0 || x_diff == COORD_BITS'(1)) &&
      (y_diff == '0 || y_diff == COORD_BITS'(1) || y_diff == '1))
    else $error("consecutive pixels not adjacent");

  // within a line, every pixel moves
  a_moves: assert property (@(posedge clk) disable iff (!rst_n)
    mid_line_pop ##1 !out_empty |-> (x_diff != '0) || (y_diff != '0))
    else $error("pixel repeated within a line");

endmodule

bind midpoint_line_color_raster mlcr_checker #(.COORD_BITS(COORD_BITS)) u_mlcr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_pixel_x     (out_pixel_x),
  .out_pixel_y     (out_pixel_y),
  .out_pixel_red   (out_pixel_red),
  .out_pixel_green (out_pixel_green),
  .out_pixel_blue  (out_pixel_blue),
  .out_last_pixel  (out_last_pixel)
);

`default_nettype wire

@@ tb/mlcr_line_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlcr_line_checker
// Watches the command and pixel channels of the line rasterizer, works out
// the pixels each accepted line must produce and compares every popped beat.
// ----------------------------------------------------------------------------
module mlcr_line_checker #(
  parameter int COORD_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic                         in_full,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  mlcr_pkg::color_t             in_start_red,
  input  mlcr_pkg::color_t             in_start_green,
  input  mlcr_pkg::color_t             in_start_blue,
  input  mlcr_pkg::color_t             in_end_red,
  input  mlcr_pkg::color_t             in_end_green,
  input  mlcr_pkg::color_t             in_end_blue,
  input  logic                         out_empty,
  input  logic                         out_pop,
  input  logic signed [COORD_BITS-1:0] out_pixel_x,
  input  logic signed [COORD_BITS-1:0] out_pixel_y,
  input  mlcr_pkg::color_t             out_pixel_red,
  input  mlcr_pkg::color_t             out_pixel_green,
  input  mlcr_pkg::color_t             out_pixel_blue,
  input  logic                         out_last_pixel,
  output int                           mismatches,
  output int                           pixels_owed,
  output int                           lines_taken,
  output int                           blank_lines,
  output int                           pixels_checked
);
  import mlcr_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t red;
    color_t green;
    color_t blue;
    logic   last;
  } pixel_t;

  pixel_t pending_pixels[$];

  // walker state left behind by the last line
  coord_t     walk_x;
  coord_t     walk_y;
  logic [8:0] walk_decision;
  logic [5:0] walk_count;
  octant_t    walk_octant;

  // round to nearest, ties up; numerator is never negative
  function automatic color_t blend(int c0, int c1, int k, int len);
    int num;
    num = c0 * len + (c1 - c0) * k + len / 2;
    return color_t'(num / len);
  endfunction

  task automatic raster_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                             rgb_t sc, rgb_t ec);
    int      x0, y0, x1, y1, dx, dy, len, d, x, y;
    rgb_t    c0, c1;
    octant_t oct;
    pixel_t  px;
    x0 = sx; y0 = sy; x1 = ex; y1 = ey; c0 = sc; c1 = ec;
    // order so x rises; colors travel with their endpoints
    if (x0 > x1) begin
      x0 = ex; y0 = ey; x1 = sx; y1 = sy; c0 = ec; c1 = sc;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    if (dx == 0 && dy == 0) begin
      walk_x = '0; walk_y = '0; walk_decision = '0; walk_count = '0;
      walk_octant = OCT_SHALLOW_UP;
      blank_lines++;
      return;
    end
    if (dy >= 0) oct = (dy <= dx) ? OCT_SHALLOW_UP : OCT_STEEP_UP;
    else         oct = (-dy <= dx) ? OCT_SHALLOW_DN : OCT_STEEP_DN;
    len = (oct == OCT_SHALLOW_UP || oct == OCT_SHALLOW_DN) ? dx : ((dy < 0) ? -dy : dy);
    case (oct)
      OCT_SHALLOW_UP: d = 2 * dy - dx;
      OCT_STEEP_UP:   d = 2 * dx - dy;
      OCT_SHALLOW_DN: d = 2 * dy + dx;
      default:        d = 2 * dx + dy;
    endcase
    x = x0;
    y = y0;
    for (int k = 1; k <= len; k++) begin
      case (oct)
        OCT_SHALLOW_UP: begin
          if (d <= 0) d += 2 * dy;
          else begin d += 2 * (dy - dx); y++; end
          x++;
        end
        OCT_STEEP_UP: begin
          if (d <= 0) d += 2 * dx;
          else begin d += 2 * (dx - dy); x++; end
          y++;
        end
        OCT_SHALLOW_DN: begin
          // this octant steps diagonally on a tie
          if (d > 0) d += 2 * dy;
          else begin d += 2 * (dy + dx); y--; end
          x++;
        end
        default: begin
          if (d <= 0) d += 2 * dx;
          else begin d += 2 * (dx + dy); x++; end
          y--;
        end
      endcase
      px.x     = coord_t'(x);
      px.y     = coord_t'(y);
      px.red   = blend(c0.red,   c1.red,   k, len);
      px.green = blend(c0.green, c1.green, k, len);
      px.blue  = blend(c0.blue,  c1.blue,  k, len);
      px.last  = (k == len);
      pending_pixels.push_back(px);
    end
    walk_x        = coord_t'(x);
    walk_y        = coord_t'(y);
    walk_decision = d[8:0];
    walk_count    = len[5:0];
    walk_octant   = oct;
  endtask

  always @(posedge clk) begin
    pixel_t exp_px;
    rgb_t   sc, ec;
    if (!rst_n) begin
      pending_pixels.delete();
      walk_x = '0; walk_y = '0; walk_decision = '0; walk_count = '0;
      walk_octant = OCT_SHALLOW_UP;
      mismatches = 0; lines_taken = 0; blank_lines = 0; pixels_checked = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected pixel x=%0d y=%0d rgb=%0d/%0d/%0d last=%0b", $time,
                     out_pixel_x, out_pixel_y, out_pixel_red, out_pixel_green,
                     out_pixel_blue, out_last_pixel);
        end else begin
          exp_px = pending_pixels.pop_front();
          pixels_checked++;
          if (out_pixel_x !== exp_px.x || out_pixel_y !== exp_px.y ||
              out_pixel_red !== exp_px.red || out_pixel_green !== exp_px.green ||
              out_pixel_blue !== exp_px.blue || out_last_pixel !== exp_px.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: pixel mismatch", $time);
              $display("  expected x=%0d y=%0d rgb=%0d/%0d/%0d last=%0b", exp_px.x,
                       exp_px.y, exp_px.red, exp_px.green, exp_px.blue, exp_px.last);
              $display("  actual   x=%0d y=%0d rgb=%0d/%0d/%0d last=%0b", out_pixel_x,
                       out_pixel_y, out_pixel_red, out_pixel_green, out_pixel_blue,
                       out_last_pixel);
            end
          end
        end
      end
      if (in_push && !in_full) begin
        sc.red = in_start_red; sc.green = in_start_green; sc.blue = in_start_blue;
        ec.red = in_end_red;   ec.green = in_end_green;   ec.blue = in_end_blue;
        lines_taken++;
        raster_line(in_start_x, in_start_y, in_end_x, in_end_y, sc, ec);
      end
    end
    pixels_owed = pending_pixels.size();
  end

endmodule

@@ tb/tb_midpoint_line_color_raster.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midpoint_line_color_raster
// Drives line commands into the rasterizer and pops its pixel beats: a set of
// hand-picked lines (octant edges, decision ties, swaps, coincident and
// longest lines) followed by randomized lines, with random gaps on both
// sides. The checker instance predicts and compares; this module only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_midpoint_line_color_raster;
  import mlcr_pkg::*;

  localparam int CB = 6;
  localparam int RANDOM_LINES = 400;

  typedef logic signed [CB-1:0] coord_t;

  logic   clk;
  logic   rst_n;
  logic   in_push;
  logic   in_full;
  coord_t in_start_x, in_start_y, in_end_x, in_end_y;
  color_t in_start_red, in_start_green, in_start_blue;
  color_t in_end_red, in_end_green, in_end_blue;
  logic   out_empty;
  logic   out_pop;
  coord_t out_pixel_x, out_pixel_y;
  color_t out_pixel_red, out_pixel_green, out_pixel_blue;
  logic   out_last_pixel;

  // checker results
  int mismatches;
  int pixels_owed;
  int lines_taken;
  int blank_lines;
  int pixels_checked;

  // percent of cycles in which the command side holds back
  int push_gap_pct;

  midpoint_line_color_raster #(.COORD_BITS(CB)) DUT (.*);

  mlcr_line_checker #(.COORD_BITS(CB)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic rgb_t rgb(int r, int g, int b);
    rgb_t c;
    c.red = color_t'(r); c.green = color_t'(g); c.blue = color_t'(b);
    return c;
  endfunction

  // color channel, biased toward the rails now and then
  function automatic int pick_channel();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 0;
    if (r == 1) return 255;
    return $urandom_range(255);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(63)) - 32;
  endfunction

  function automatic int clamp_coord(int v);
    return (v < -32) ? -32 : ((v > 31) ? 31 : v);
  endfunction

  // One command beat. Inputs move on the falling edge; the beat is taken at
  // the first rising edge where in_full is low. in_push stays high into the
  // next call unless that call opens with a gap.
  task automatic offer_line(int sx, int sy, int ex, int ey, rgb_t sc, rgb_t ec);
    @(negedge clk);
    while (push_gap_pct > 0 && $urandom_range(99) < push_gap_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push        = 1'b1;
    in_start_x     = coord_t'(sx);
    in_start_y     = coord_t'(sy);
    in_end_x       = coord_t'(ex);
    in_end_y       = coord_t'(ey);
    in_start_red   = sc.red;
    in_start_green = sc.green;
    in_start_blue  = sc.blue;
    in_end_red     = ec.red;
    in_end_green   = ec.green;
    in_end_blue    = ec.blue;
    do @(posedge clk); while (in_full);
  endtask

  // Random line: mostly arbitrary endpoints, with short lines, axis and
  // diagonal lines and coincident endpoints mixed in.
  task automatic offer_random_line();
    int   sx, sy, ex, ey, n, mode;
    rgb_t sc, ec;
    sc = rgb(pick_channel(), pick_channel(), pick_channel());
    ec = rgb(pick_channel(), pick_channel(), pick_channel());
    sx = rand_coord();
    sy = rand_coord();
    mode = $urandom_range(99);
    if (mode < 55) begin
      ex = rand_coord();
      ey = rand_coord();
    end else if (mode < 80) begin
      ex = clamp_coord(sx + int'($urandom_range(8)) - 4);
      ey = clamp_coord(sy + int'($urandom_range(8)) - 4);
    end else if (mode < 92) begin
      n = int'($urandom_range(40)) - 20;
      case ($urandom_range(3))
        0:       begin ex = clamp_coord(sx + n); ey = sy; end
        1:       begin ex = sx; ey = clamp_coord(sy + n); end
        2:       begin ex = clamp_coord(sx + n); ey = clamp_coord(sy + n); end
        default: begin ex = clamp_coord(sx + n); ey = clamp_coord(sy - n); end
      endcase
    end else begin
      ex = sx;
      ey = sy;
    end
    offer_line(sx, sy, ex, ey, sc, ec);
  endtask

  // Pixel side: random pops, one long hold-off while commands keep coming
  // (fills both internal queues and pushes back on in_full), and a long
  // stretch of popping every cycle.
  initial begin
    int cyc;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 1500 && cyc < 1900)
        out_pop = 1'b0;
      else if (cyc >= 5000 && cyc < 8000)
        out_pop = 1'b1;
      else
        out_pop = ($urandom_range(99) >= 29);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    out_pop = 1'b0;
    in_start_x = '0; in_start_y = '0; in_end_x = '0; in_end_y = '0;
    in_start_red = '0; in_start_green = '0; in_start_blue = '0;
    in_end_red = '0; in_end_green = '0; in_end_blue = '0;
    push_gap_pct = 29;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed lines ---
    // axis lines; vertical ones are steep, picked by the sign of dy
    offer_line(0, 0, 5, 0, rgb(0, 0, 0), rgb(255, 255, 255));
    offer_line(0, 0, 0, 5, rgb(255, 255, 255), rgb(0, 0, 0));
    offer_line(0, 5, 0, 0, rgb(255, 0, 128), rgb(0, 255, 127));
    // slope +1 and -1 across the whole grid, with and without the swap
    offer_line(-32, -32, 31, 31, rgb(0, 128, 255), rgb(255, 127, 0));
    offer_line(31, -32, -32, 31, rgb(10, 200, 30), rgb(250, 5, 99));
    offer_line(-32, 31, 31, -32, rgb(255, 255, 255), rgb(0, 0, 0));
    // coincident endpoints: no pixels, walker state cleared
    offer_line(3, 3, 3, 3, rgb(1, 2, 3), rgb(4, 5, 6));
    offer_line(-32, -32, -32, -32, rgb(255, 255, 255), rgb(0, 0, 0));
    offer_line(31, 31, 31, 31, rgb(0, 0, 0), rgb(255, 255, 255));
    // decision starts at zero in each octant
    offer_line(0, 0, 2, 1, rgb(0, 0, 0), rgb(3, 3, 3));
    offer_line(0, 0, 2, -1, rgb(3, 3, 3), rgb(0, 0, 0));
    offer_line(0, 0, 1, 2, rgb(100, 101, 102), rgb(101, 100, 103));
    offer_line(0, 0, 1, -2, rgb(7, 8, 9), rgb(9, 8, 7));
    // full-width axis lines
    offer_line(-32, 0, 31, 0, rgb(0, 255, 0), rgb(255, 0, 255));
    offer_line(0, -32, 0, 31, rgb(255, 0, 0), rgb(0, 0, 255));
    offer_line(0, 31, 0, -32, rgb(0, 0, 255), rgb(255, 0, 0));
    // swapped shallow and steep lines
    offer_line(10, 0, 0, 3, rgb(200, 50, 25), rgb(25, 50, 200));
    offer_line(5, -20, -3, 20, rgb(0, 255, 255), rgb(255, 255, 0));
    // single-step lines
    offer_line(0, 0, 1, 0, rgb(0, 0, 0), rgb(255, 255, 255));
    offer_line(0, 0, 0, -1, rgb(255, 255, 255), rgb(0, 0, 0));
    // near-horizontal and near-vertical full-length lines, and a swapped shallow line
    offer_line(-32, -32, 31, -31, rgb(17, 34, 51), rgb(240, 220, 200));
    offer_line(-20, -32, -19, 31, rgb(128, 128, 128), rgb(129, 127, 255));
    offer_line(7, -5, -25, 9, rgb(60, 70, 80), rgb(90, 0, 255));

    // --- random lines, with a long stretch of back-to-back beats ---
    for (int i = 0; i < RANDOM_LINES; i++) begin
      push_gap_pct = (i >= 150 && i < 230) ? 0 : 29;
      offer_random_line();
    end
    @(negedge clk);
    in_push = 1'b0;

    // drain, then leave room for a trailing line with no pixels
    while (pixels_owed != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("Drew %0d line commands (%0d with coincident endpoints) and checked %0d pixels.",
             lines_taken, blank_lines, pixels_checked);
    $display("Mismatched pixel beats: %0d, pixels still owed: %0d.", mismatches, pixels_owed);
    if (mismatches == 0 && pixels_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mlcr_pkg.sv
rtl/mlcr_fifo.sv
rtl/mlcr_front.sv
rtl/mlcr_back.sv
rtl/midpoint_line_color_raster.sv
rtl/mlcr_checker.sv
tb/mlcr_line_checker.sv
tb/tb_midpoint_line_color_raster.sv
